### hdl/dtk_pkg.sv
// Package: shared widths, table control struct and sequencer states for the top-K tracker.
`timescale 1ns / 1ps

package dtk_pkg;

   localparam int TOP_ROWS_DEF = 8;
   localparam int MAX_EMIT     = 8;
   localparam int ID_W         = 22;
   localparam int CPU_W        = 24;
   localparam int MEM_W        = 48;
   localparam int RANK_W       = 3;

   // per-cycle commands from the sequencer to both rank tables
   typedef struct packed {
      logic start;     // load a new record into the carry register
      logic rd_en;     // read the entry at rd_addr
      logic ins_step;  // compare/shift step on last read entry
      logic clr_wr;    // write an empty entry at wr_addr
   } dtk_tbl_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_EMIT_RD,
      ST_EMIT_WR
   } dtk_state_type;

endpackage

### hdl/dtk_if.sv
// Interfaces: record request channel and rank row response channel.
`timescale 1ns / 1ps

interface dtk_req_if;
   logic                      valid;
   logic                      ready;
   logic [dtk_pkg::ID_W-1:0]  proc_id;
   logic [dtk_pkg::CPU_W-1:0] cpu_load;
   logic [dtk_pkg::MEM_W-1:0] mem_bytes;
   logic                      batch_end;

   modport source (output valid, output proc_id, output cpu_load, output mem_bytes,
                   output batch_end, input ready);
   modport sink   (input valid, input proc_id, input cpu_load, input mem_bytes,
                   input batch_end, output ready);
endinterface

interface dtk_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [dtk_pkg::RANK_W-1:0] rank;
   logic                       cpu_row_valid;
   logic [dtk_pkg::ID_W-1:0]   cpu_row_id;
   logic [dtk_pkg::CPU_W-1:0]  cpu_row_load;
   logic                       mem_row_valid;
   logic [dtk_pkg::ID_W-1:0]   mem_row_id;
   logic [dtk_pkg::MEM_W-1:0]  mem_row_bytes;
   logic                       final_row;

   modport source (output valid, output rank, output cpu_row_valid, output cpu_row_id,
                   output cpu_row_load, output mem_row_valid, output mem_row_id,
                   output mem_row_bytes, output final_row, input ready);
   modport sink   (input valid, input rank, input cpu_row_valid, input cpu_row_id,
                   input cpu_row_load, input mem_row_valid, input mem_row_id,
                   input mem_row_bytes, input final_row, output ready);
endinterface

### hdl/dtk_rank_table.sv
// Rank table: sorted entry memory with a carry register for insertion by shifting.
`timescale 1ns / 1ps

module dtk_rank_table #(
   parameter int TOP_ROWS = dtk_pkg::TOP_ROWS_DEF,
   parameter int VAL_W    = dtk_pkg::CPU_W,
   parameter int ADDR_W   = (TOP_ROWS > 1) ? $clog2(TOP_ROWS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dtk_pkg::dtk_tbl_ctl_type ctl,
   input  logic [ADDR_W-1:0]        rd_addr,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [dtk_pkg::ID_W-1:0] id_in,
   input  logic [VAL_W-1:0]         val_in,
   output logic                     row_valid,
   output logic [dtk_pkg::ID_W-1:0] row_id,
   output logic [VAL_W-1:0]         row_val
);
   import dtk_pkg::*;

   localparam int EntW = 1 + ID_W + VAL_W;

   // entry: {valid, id, value}
   logic [EntW-1:0]  mem [TOP_ROWS];
   logic [EntW-1:0]  rdata_ff;
   logic [EntW-1:0]  carry_ff, carry_in;
   logic [VAL_W-1:0] rec_val_ff, rec_val_in;
   logic             shifting_ff, shifting_in;

   logic             e_valid;
   logic [ID_W-1:0]  e_id;
   logic [VAL_W-1:0] e_val;
   logic             take;
   logic             wr_en;
   logic [EntW-1:0]  wr_data;

   assign e_valid = rdata_ff[EntW-1];
   assign e_id    = rdata_ff[VAL_W +: ID_W];
   assign e_val   = rdata_ff[VAL_W-1:0];

   // once placed, every later rank is pushed down by one
   assign take    = shifting_ff || !e_valid || (e_val < rec_val_ff);
   assign wr_en   = ctl.clr_wr || (ctl.ins_step && take);
   assign wr_data = ctl.clr_wr ? '0 : carry_ff;

   always_comb begin
      carry_in    = carry_ff;
      rec_val_in  = rec_val_ff;
      shifting_in = shifting_ff;
      if (ctl.start) begin
         carry_in    = {1'b1, id_in, val_in};
         rec_val_in  = val_in;
         shifting_in = 1'b0;
      end else if (ctl.ins_step && take) begin
         carry_in    = rdata_ff;
         shifting_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      carry_ff   <= carry_in;
      rec_val_ff <= rec_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shifting_ff <= 1'b0;
      end else begin
         shifting_ff <= shifting_in;
      end
   end

   assign row_valid = e_valid;
   assign row_id    = e_valid ? e_id : '0;
   assign row_val   = e_valid ? e_val : '0;

endmodule

### hdl/dtk_ctrl.sv
// Sequencer: clear pass, insertion walk and row readout over both rank tables.
`timescale 1ns / 1ps

module dtk_ctrl #(
   parameter int TOP_ROWS = dtk_pkg::TOP_ROWS_DEF,
   parameter int ADDR_W   = (TOP_ROWS > 1) ? $clog2(TOP_ROWS) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_batch_end,
   output logic                       req_ready,
   input  logic                       out_free,
   output dtk_pkg::dtk_tbl_ctl_type   ctl,
   output logic [ADDR_W-1:0]          rd_addr,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic                       out_load,
   output logic [dtk_pkg::RANK_W-1:0] out_rank,
   output logic                       out_final
);
   import dtk_pkg::*;

   localparam int IdxW     = $clog2(TOP_ROWS + 1);
   localparam int EmitRows = (TOP_ROWS < MAX_EMIT) ? TOP_ROWS : MAX_EMIT;

   dtk_state_type   state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            end_ff, end_in;
   logic [IdxW-1:0] idx_m1;
   logic            is_last, walk_done, emit_row, row_go;

   assign idx_m1    = idx_ff - IdxW'(1);
   assign is_last   = (idx_ff == IdxW'(TOP_ROWS - 1));
   assign walk_done = (idx_ff == IdxW'(TOP_ROWS));
   assign emit_row  = (idx_ff < IdxW'(EmitRows));
   assign row_go    = !emit_row || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      end_in   = end_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (is_last) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_INSERT;
               idx_in   = '0;
               end_in   = req_batch_end;
            end
         end
         ST_INSERT: begin
            if (walk_done) begin
               state_in = end_ff ? ST_EMIT_RD : ST_IDLE;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (row_go) begin
               if (is_last) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  state_in = ST_EMIT_RD;
                  idx_in   = idx_ff + IdxW'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      wr_addr   = idx_ff[ADDR_W-1:0];
      out_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_wr = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.start = req_valid;
         end
         ST_INSERT: begin
            // read rank idx while the entry read last cycle is compared and the carry is written at idx-1
            ctl.rd_en    = !walk_done;
            ctl.ins_step = (idx_ff != '0);
            wr_addr      = idx_m1[ADDR_W-1:0];
         end
         ST_EMIT_RD: begin
            ctl.rd_en = 1'b1;
         end
         ST_EMIT_WR: begin
            ctl.clr_wr = row_go;
            out_load   = row_go && emit_row;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   assign out_rank  = RANK_W'(idx_ff);
   assign out_final = (idx_ff == IdxW'(EmitRows - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         end_ff   <= end_in;
      end
   end

endmodule

### hdl/dual_top_k_tracker.sv
// Top level: dual top-K tracker ranking process records by CPU load and by memory size.
//
//  channel    dir  handshake      payload
//  req_chan   in   valid/ready    proc_id, cpu_load, mem_bytes, batch_end
//  rsp_chan   out  valid/ready    rank, cpu_row_*, mem_row_*, final_row
//
// A record is accepted, then a read/shift walk runs over the rank memories (one entry
// read and at most one written per cycle, both tables in parallel); no new record is
// accepted until the walk ends. A batch end adds a readout and clear pass, plus any
// rsp stall. After reset a clearing pass over all ranks runs with req_chan.ready low.
// The response register lets the walk go on while a row waits to be taken.
`timescale 1ns / 1ps

module dual_top_k_tracker #(
   parameter int TOP_ROWS = dtk_pkg::TOP_ROWS_DEF
) (
   input logic       clock,
   input logic       reset,
   dtk_req_if.sink   req_chan,
   dtk_rsp_if.source rsp_chan
);
   import dtk_pkg::*;

   localparam int AddrW = (TOP_ROWS > 1) ? $clog2(TOP_ROWS) : 1;

   dtk_tbl_ctl_type   ctl;
   logic [AddrW-1:0]  rd_addr, wr_addr;
   logic              out_load, out_final, out_free;
   logic [RANK_W-1:0] out_rank;

   logic              cpu_valid, mem_valid;
   logic [ID_W-1:0]   cpu_id, mem_id;
   logic [CPU_W-1:0]  cpu_val;
   logic [MEM_W-1:0]  mem_val;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0] rank_ff;
   logic              cpu_valid_ff, mem_valid_ff, final_ff;
   logic [ID_W-1:0]   cpu_id_ff, mem_id_ff;
   logic [CPU_W-1:0]  cpu_val_ff;
   logic [MEM_W-1:0]  mem_val_ff;

   dtk_ctrl #(.TOP_ROWS(TOP_ROWS), .ADDR_W(AddrW)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_batch_end (req_chan.batch_end),
      .req_ready     (req_chan.ready),
      .out_free      (out_free),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .out_load      (out_load),
      .out_rank      (out_rank),
      .out_final     (out_final)
   );

   dtk_rank_table #(.TOP_ROWS(TOP_ROWS), .VAL_W(CPU_W), .ADDR_W(AddrW)) u_cpu_tbl (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .id_in     (req_chan.proc_id),
      .val_in    (req_chan.cpu_load),
      .row_valid (cpu_valid),
      .row_id    (cpu_id),
      .row_val   (cpu_val)
   );

   dtk_rank_table #(.TOP_ROWS(TOP_ROWS), .VAL_W(MEM_W), .ADDR_W(AddrW)) u_mem_tbl (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .id_in     (req_chan.proc_id),
      .val_in    (req_chan.mem_bytes),
      .row_valid (mem_valid),
      .row_id    (mem_id),
      .row_val   (mem_val)
   );

   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rank_ff      <= out_rank;
         cpu_valid_ff <= cpu_valid;
         cpu_id_ff    <= cpu_id;
         cpu_val_ff   <= cpu_val;
         mem_valid_ff <= mem_valid;
         mem_id_ff    <= mem_id;
         mem_val_ff   <= mem_val;
         final_ff     <= out_final;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.rank          = rank_ff;
   assign rsp_chan.cpu_row_valid = cpu_valid_ff;
   assign rsp_chan.cpu_row_id    = cpu_id_ff;
   assign rsp_chan.cpu_row_load  = cpu_val_ff;
   assign rsp_chan.mem_row_valid = mem_valid_ff;
   assign rsp_chan.mem_row_id    = mem_id_ff;
   assign rsp_chan.mem_row_bytes = mem_val_ff;
   assign rsp_chan.final_row     = final_ff;

endmodule

### hdl/dtk_checker.sv
// Checker: port-level properties of the top-K tracker, bound to the top level.
`timescale 1ns / 1ps

module dtk_checker #(
   parameter int TOP_ROWS = dtk_pkg::TOP_ROWS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_batch_end,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [dtk_pkg::RANK_W-1:0] rsp_rank,
   input logic                       rsp_cpu_row_valid,
   input logic                       rsp_mem_row_valid,
   input logic                       rsp_final_row
);
   import dtk_pkg::*;

   localparam int EmitRows = (TOP_ROWS < MAX_EMIT) ? TOP_ROWS : MAX_EMIT;

   // clearing pass after reset blocks new records
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("record accepted during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a record that does not end the batch starts no new row
   a_no_row_mid_batch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_batch_end |=> !$rose(rsp_valid))
      else $error("row started without batch end");

   // both tables always hold the same count, and an emitted rank 0 row is never empty
   a_tables_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cpu_row_valid == rsp_mem_row_valid)
                    && (rsp_rank != '0 || rsp_cpu_row_valid))
      else $error("table row occupancy mismatch");

   a_final_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_row |-> rsp_rank == RANK_W'(EmitRows - 1))
      else $error("final row at wrong rank");

endmodule

bind dual_top_k_tracker dtk_checker #(.TOP_ROWS(TOP_ROWS)) u_dtk_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_batch_end     (req_chan.batch_end),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_rank          (rsp_chan.rank),
   .rsp_cpu_row_valid (rsp_chan.cpu_row_valid),
   .rsp_mem_row_valid (rsp_chan.mem_row_valid),
   .rsp_final_row     (rsp_chan.final_row)
);
